### rtl/core/asid_allocator_with_quarantine_core_macros.svh
// ----------------------------------------------------------------------------
// asid allocator assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef ASID_ALLOCATOR_WITH_QUARANTINE_CORE_MACROS_SVH
`define ASID_ALLOCATOR_WITH_QUARANTINE_CORE_MACROS_SVH

// same-cycle implication
`define ASWQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aswq assertion failed");

// next-cycle implication
`define ASWQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aswq assertion failed");

`endif

### rtl/core/aswq_pkg.sv
// ----------------------------------------------------------------------------
// aswq_pkg
// types, constants and helpers of the asid allocator
// ----------------------------------------------------------------------------
package aswq_pkg;

  localparam int ID_BITS       = 16;
  localparam int WORD_BITS     = 64;
  localparam int BIT_IDX_BITS  = $clog2(WORD_BITS);
  localparam int WORD_IDX_BITS = ID_BITS - BIT_IDX_BITS;
  localparam int MAP_WORDS     = 2 ** WORD_IDX_BITS;

  localparam logic       OP_ALLOC   = 1'b0;
  localparam logic       OP_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNSUP   = 2'd1;
  localparam logic [1:0] ST_EXHAUST = 2'd2;
  localparam logic [1:0] ST_DOUBLE  = 2'd3;

  localparam logic [1:0] FL_NONE    = 2'd0;
  localparam logic [1:0] FL_LOCAL   = 2'd1;
  localparam logic [1:0] FL_GLOBAL  = 2'd2;

  typedef struct packed {
    logic        op;
    logic [15:0] asid;
  } in_item_t;

  typedef struct packed {
    logic [15:0] granted_asid;
    logic [1:0]  status;
    logic [1:0]  flush;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SEED, S_CHECK, S_START, S_SCAN_RD, S_SCAN_EV, S_SEG_B,
    S_PASS_END, S_REB_RD, S_REB_WR, S_EXHAUST, S_REL_RD, S_REL_EV, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    C_NONE, C_CLEAR, C_LOAD, C_SEED, C_LIMIT0, C_START, C_SCAN_EV, C_SEG_B,
    C_PASS_END, C_REB_WR, C_EXHAUST, C_REL_EV, C_PUSH
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
  } dp_cmd_t;

  typedef struct packed {
    logic wlast;
    logic seeded;
    logic limit_zero;
    logic hit;
    logic seg_end;
    logic seg_a;
    logic cur_gt1;
    logic exhaust;
    logic out_free;
  } dp_stat_t;

  // bits of word w whose ids fall in lo..hi
  function automatic logic [WORD_BITS-1:0] range_mask(
    input logic [WORD_IDX_BITS-1:0] w,
    input logic [ID_BITS-1:0]       lo,
    input logic [ID_BITS-1:0]       hi
  );
    logic [WORD_BITS-1:0]     ones;
    logic [WORD_BITS-1:0]     ge;
    logic [WORD_BITS-1:0]     le;
    logic [WORD_IDX_BITS-1:0] lo_w;
    logic [WORD_IDX_BITS-1:0] hi_w;
    logic [BIT_IDX_BITS-1:0]  top;
    ones = '1;
    lo_w = lo[ID_BITS-1:BIT_IDX_BITS];
    hi_w = hi[ID_BITS-1:BIT_IDX_BITS];
    top  = BIT_IDX_BITS'(WORD_BITS - 1) - hi[BIT_IDX_BITS-1:0];
    if (w > lo_w)       ge = ones;
    else if (w == lo_w) ge = ones << lo[BIT_IDX_BITS-1:0];
    else                ge = '0;
    if (w < hi_w)       le = ones;
    else if (w == hi_w) le = ones >> top;
    else                le = '0;
    return ge & le;
  endfunction

  function automatic logic [BIT_IDX_BITS-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_IDX_BITS-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_IDX_BITS'(i);
    end
    return idx;
  endfunction

endpackage

### rtl/core/aswq_ctrl.sv
// ----------------------------------------------------------------------------
// aswq_ctrl
// sequencer for clear, seed, scan, rebuild and release
// ----------------------------------------------------------------------------
module aswq_ctrl import aswq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:    if (stat.wlast) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_RELEASE) state_nxt = S_REL_RD;
          else if (stat.seeded)    state_nxt = S_CHECK;
          else                     state_nxt = S_SEED;
        end
      end
      S_SEED:     if (stat.wlast) state_nxt = S_CHECK;
      S_CHECK:    state_nxt = stat.limit_zero ? S_DONE : S_START;
      S_START:    state_nxt = S_SCAN_RD;
      S_SCAN_RD:  state_nxt = S_SCAN_EV;
      S_SCAN_EV: begin
        priority if (stat.hit)                   state_nxt = S_DONE;
        else if (!stat.seg_end)                  state_nxt = S_SCAN_RD;
        else if (stat.seg_a && stat.cur_gt1)     state_nxt = S_SEG_B;
        else                                     state_nxt = S_PASS_END;
      end
      S_SEG_B:    state_nxt = S_SCAN_RD;
      S_PASS_END: state_nxt = S_REB_RD;
      S_REB_RD:   state_nxt = S_REB_WR;
      S_REB_WR: begin
        if (stat.wlast) state_nxt = stat.exhaust ? S_EXHAUST : S_START;
        else            state_nxt = S_REB_RD;
      end
      S_EXHAUST:  state_nxt = S_DONE;
      S_REL_RD:   state_nxt = S_REL_EV;
      S_REL_EV:   state_nxt = S_DONE;
      S_DONE:     if (stat.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd.cmd  = C_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLEAR:    cmd.cmd = C_CLEAR;
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.cmd = C_LOAD;
      end
      S_SEED:     cmd.cmd = C_SEED;
      S_CHECK:    if (stat.limit_zero) cmd.cmd = C_LIMIT0;
      S_START:    cmd.cmd = C_START;
      S_SCAN_EV:  cmd.cmd = C_SCAN_EV;
      S_SEG_B:    cmd.cmd = C_SEG_B;
      S_PASS_END: cmd.cmd = C_PASS_END;
      S_REB_WR:   cmd.cmd = C_REB_WR;
      S_EXHAUST:  cmd.cmd = C_EXHAUST;
      S_REL_EV:   cmd.cmd = C_REL_EV;
      S_DONE:     if (stat.out_free) cmd.cmd = C_PUSH;
      default:    cmd.cmd = C_NONE;
    endcase
  end

endmodule

### rtl/core/aswq_dp.sv
// ----------------------------------------------------------------------------
// aswq_dp
// bitmap memories, cursor, scan bounds and result register
// ----------------------------------------------------------------------------
module aswq_dp import aswq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  in_item_t    in_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic [15:0] id_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  logic [WORD_BITS-1:0] live_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] elig_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] live_rd_r, elig_rd_r;

  logic [WORD_IDX_BITS-1:0] w_r, w_nxt;
  logic [ID_BITS-1:0]       cursor_r, cursor_nxt;
  logic [ID_BITS-1:0]       lo_r, lo_nxt, hi_r, hi_nxt;
  logic [ID_BITS-1:0]       id_r, id_nxt;
  logic                     seg_r, seg_nxt;
  logic [1:0]               pass_r, pass_nxt;
  logic                     seeded_r, seeded_nxt;
  logic [15:0]              id_limit_r;
  out_item_t                res_r, res_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_r, out_nxt;

  logic [ID_BITS-1:0]       limit;
  logic [ID_BITS-1:0]       fixed_cur;
  logic [WORD_BITS-1:0]     cand_bits;
  logic [BIT_IDX_BITS-1:0]  cand_bit;
  logic [ID_BITS-1:0]       cand;
  logic [WORD_BITS-1:0]     cand_onehot;
  logic [WORD_BITS-1:0]     rel_onehot;
  logic [WORD_BITS-1:0]     full_range;
  logic                     live_we, elig_we;
  logic [WORD_BITS-1:0]     live_wd, elig_wd;

  assign limit       = id_limit_r;
  assign fixed_cur   = (cursor_r == '0 || cursor_r > limit) ? ID_BITS'(1) : cursor_r;
  assign cand_bits   = elig_rd_r & range_mask(w_r, lo_r, hi_r);
  assign cand_bit    = lowest_set(cand_bits);
  assign cand        = {w_r, cand_bit};
  assign cand_onehot = WORD_BITS'(1) << cand_bit;
  assign rel_onehot  = WORD_BITS'(1) << id_r[BIT_IDX_BITS-1:0];
  assign full_range  = range_mask(w_r, ID_BITS'(1), limit);
  assign id_limit    = id_limit_r;
  assign out_valid   = out_valid_r;
  assign out_data    = out_r;

  assign stat.wlast      = &w_r;
  assign stat.seeded     = seeded_r;
  assign stat.limit_zero = (limit == '0);
  assign stat.hit        = |cand_bits;
  assign stat.seg_end    = (w_r == hi_r[ID_BITS-1:BIT_IDX_BITS]);
  assign stat.seg_a      = !seg_r;
  assign stat.cur_gt1    = (cursor_r > ID_BITS'(1));
  assign stat.exhaust    = pass_r[1];
  assign stat.out_free   = !out_valid_r || out_ready;

  always_comb begin
    live_we = 1'b0;
    elig_we = 1'b0;
    live_wd = live_rd_r;
    elig_wd = elig_rd_r;
    unique case (cmd.cmd)
      C_CLEAR: begin
        live_we = 1'b1;
        elig_we = 1'b1;
        live_wd = '0;
        elig_wd = '0;
      end
      C_SEED: begin
        elig_we = 1'b1;
        elig_wd = full_range;
      end
      C_SCAN_EV: begin
        if (|cand_bits) begin
          live_we = 1'b1;
          elig_we = 1'b1;
          live_wd = live_rd_r | cand_onehot;
          elig_wd = elig_rd_r & ~cand_onehot;
        end
      end
      C_REB_WR: begin
        elig_we = 1'b1;
        elig_wd = ~live_rd_r & full_range;
      end
      C_REL_EV: begin
        if (id_r != '0 && (live_rd_r & rel_onehot) != '0) begin
          live_we = 1'b1;
          live_wd = live_rd_r & ~rel_onehot;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (live_we) live_mem[w_r] <= live_wd;
    if (elig_we) elig_mem[w_r] <= elig_wd;
    live_rd_r <= live_mem[w_r];
    elig_rd_r <= elig_mem[w_r];
  end

  always_comb begin
    w_nxt      = w_r;
    cursor_nxt = cursor_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    id_nxt     = id_r;
    seg_nxt    = seg_r;
    pass_nxt   = pass_r;
    seeded_nxt = seeded_r;
    res_nxt    = res_r;
    out_nxt    = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (cmd.cmd)
      C_CLEAR:  w_nxt = w_r + 1'b1;
      C_LOAD: begin
        id_nxt   = in_data.asid;
        // releases read the word of their id, the seeding sweep starts at word 0
        if (in_data.op == OP_RELEASE) w_nxt = in_data.asid[ID_BITS-1:BIT_IDX_BITS];
        else                          w_nxt = '0;
        pass_nxt = '0;
        res_nxt  = '{granted_asid: '0, status: ST_OK, flush: FL_NONE};
      end
      C_SEED: begin
        w_nxt = w_r + 1'b1;
        if (&w_r) begin
          seeded_nxt    = 1'b1;
          res_nxt.flush = FL_LOCAL;
        end
      end
      C_LIMIT0: res_nxt.status = ST_UNSUP;
      C_START: begin
        cursor_nxt = fixed_cur;
        lo_nxt     = fixed_cur;
        hi_nxt     = limit;
        seg_nxt    = 1'b0;
        w_nxt      = fixed_cur[ID_BITS-1:BIT_IDX_BITS];
      end
      C_SCAN_EV: begin
        if (|cand_bits) begin
          res_nxt.granted_asid = cand;
          cursor_nxt = (cand == limit) ? ID_BITS'(1) : cand + 1'b1;
        end else if (w_r != hi_r[ID_BITS-1:BIT_IDX_BITS]) begin
          w_nxt = w_r + 1'b1;
        end
      end
      C_SEG_B: begin
        lo_nxt  = ID_BITS'(1);
        hi_nxt  = cursor_r - 1'b1;
        seg_nxt = 1'b1;
        w_nxt   = '0;
      end
      C_PASS_END: begin
        res_nxt.flush = FL_GLOBAL;
        pass_nxt      = pass_r + 1'b1;
        w_nxt         = '0;
      end
      C_REB_WR:  w_nxt = w_r + 1'b1;
      C_EXHAUST: res_nxt.status = ST_EXHAUST;
      C_REL_EV: begin
        if (id_r != '0 && (live_rd_r & rel_onehot) == '0) res_nxt.status = ST_DOUBLE;
      end
      C_PUSH: begin
        out_nxt       = res_r;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= '0;
      cursor_r    <= ID_BITS'(1);
      seeded_r    <= 1'b0;
      pass_r      <= '0;
      seg_r       <= 1'b0;
      out_valid_r <= 1'b0;
      id_limit_r  <= 16'hffff;
    end else begin
      w_r         <= w_nxt;
      cursor_r    <= cursor_nxt;
      seeded_r    <= seeded_nxt;
      pass_r      <= pass_nxt;
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) id_limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    id_r  <= id_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

endmodule

### rtl/core/asid_allocator_with_quarantine_core.sv
// ----------------------------------------------------------------------------
// asid_allocator_with_quarantine_core
// Usage: one beat on in_ (op, asid) gives one beat on out_ (granted_asid,
// status, flush). Items are handled one at a time; the next beat is taken
// as soon as the sequencer is idle, even while a result waits in the
// output register. Steps of each item, with W = 1024 bitmap words:
//   release: read the word of its id, then evaluate it
//   allocate, hit in the first pass: scan from the cursor, then from id 1
//   first allocate adds a seeding sweep over all W words
//   each rollover adds a rebuild over all W words; worst case, exhausted
//   after two scans and two rebuilds plus seeding.
// Throughput is set by the single read port of each bitmap memory: scan
// and rebuild handle one 64-bit word at a time, reading it before use.
// After reset a clearing pass zeroes both bitmaps; no input beat is taken
// until it ends. Configuration writes are taken at any time.
// When the receiver stalls the result holds in the output register and
// the following item waits before delivering its own.
// ----------------------------------------------------------------------------
module asid_allocator_with_quarantine_core import aswq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic        cfg_we;
  logic [15:0] id_limit;
  logic        addr_hit;

  // the single register answers at every address of this space
  assign addr_hit = (paddr[1:0] == 2'b00) || (paddr[1:0] != 2'b00);
  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && addr_hit;
  assign prdata   = {16'h0, id_limit};

  aswq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  aswq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (pwdata[15:0]),
    .id_limit  (id_limit),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/core/aswq_chk.sv
// ----------------------------------------------------------------------------
// aswq_chk
// port-level checks of the asid allocator
// ----------------------------------------------------------------------------
`include "asid_allocator_with_quarantine_core_macros.svh"

module aswq_chk import aswq_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `ASWQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASWQ_ASSERT_IMPL(a_grant_ok, clk, rst_n, out_valid && out_data.granted_asid != 16'h0, out_data.status == ST_OK)
  `ASWQ_ASSERT_IMPL(a_unsup, clk, rst_n, out_valid && out_data.status == ST_UNSUP, out_data.granted_asid == 16'h0 && out_data.flush != FL_GLOBAL)
  `ASWQ_ASSERT_IMPL(a_exhaust, clk, rst_n, out_valid && out_data.status == ST_EXHAUST, out_data.granted_asid == 16'h0 && out_data.flush == FL_GLOBAL)

endmodule

bind asid_allocator_with_quarantine_core aswq_chk u_aswq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
